>>> sv/lpp_pkg.sv
package lpp_pkg;

   localparam int FIELD_W    = 32;
   localparam int LOOP_W     = 17;
   localparam int SPEED_W    = 16;
   localparam int SPEED_FRAC = 8;
   localparam int PROD_W     = FIELD_W + SPEED_W;
   localparam int STEP_W     = PROD_W - SPEED_FRAC;
   localparam int CSR_IDX_W  = 3;

   localparam logic [SPEED_W-1:0] SPEED_ONE = 16'h0100;

   localparam logic [1:0] ACT_ADVANCE = 2'd0;
   localparam logic [1:0] ACT_SEEK    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_END   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_FIRST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_COUNT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_POS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED       = 3'd6;

   typedef enum logic {
      OP_MUL,
      OP_REM
   } lpp_op_type;

   typedef struct packed {
      logic       start;
      lpp_op_type op;
   } lpp_cmd_type;

endpackage

>>> sv/lpp_if.sv
interface lpp_req_if;
   import lpp_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [FIELD_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface lpp_rsp_if;
   import lpp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [FIELD_W-1:0]       position;
   logic signed [LOOP_W-1:0] loops_left;
   logic                     changed;
   logic                     stopped;

   modport source (output valid, output position, output loops_left, output changed,
                   output stopped, input ready);
   modport sink   (input valid, input position, input loops_left, input changed,
                   input stopped, output ready);
endinterface

>>> sv/loop_playback_position_unit.sv
// Loop playback position unit.
// req_ch carries one item: action (advance by delta, seek, restart) and value.
// rsp_ch returns exactly one item per request: position, loops_left, changed,
// stopped. Both channels move an item when valid and ready are high together.
// csr_we/csr_index/csr_wdata write the range, loop points, loop count, initial
// position and speed; write them while the unit is idle. A restart loads them.
// Advance multiplies delta by speed in one shared shift/add-subtract unit, one
// speed bit per cycle through the 16-bit multiply; an advance that wraps a loop
// then takes the remainder in the same unit, one remainder bit per cycle.
// One item is in flight at a time; req_ch.ready is high only when idle.
// The response sits in an output register, so the next request is taken while
// it waits; if rsp_ch stalls, the following item holds in its last step until
// the register frees.
// Synchronous reset clears the position state and loads the register resets
// (speed 1.0, all else zero); no response is pending after reset.
module loop_playback_position_unit #(
   parameter int POS_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   lpp_req_if.sink                          req_ch,
   lpp_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [lpp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lpp_pkg::FIELD_W-1:0]      csr_wdata
);
   import lpp_pkg::*;

   localparam int XW = (POS_WIDTH > FIELD_W) ? POS_WIDTH : FIELD_W;
   localparam int CM = (POS_WIDTH > STEP_W) ? POS_WIDTH : STEP_W;
   localparam int AW = (POS_WIDTH + 1 > PROD_W) ? POS_WIDTH + 1 : PROD_W;
   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_CHECK,
      S_REM,
      S_WRAP,
      S_SEEK,
      S_FIX,
      S_SORT,
      S_CLAMP,
      S_MIRROR,
      S_DONE
   } state_type;

   function automatic logic [POS_WIDTH-1:0] clamp_pos(input logic [POS_WIDTH-1:0] x,
                                                      input logic [POS_WIDTH-1:0] lo,
                                                      input logic [POS_WIDTH-1:0] hi);
      if (x < lo) begin
         clamp_pos = lo;
      end else if (x > hi) begin
         clamp_pos = hi;
      end else begin
         clamp_pos = x;
      end
   endfunction

   function automatic logic [POS_WIDTH-1:0] mirror_pos(input logic [POS_WIDTH-1:0] x,
                                                       input logic [POS_WIDTH-1:0] lo,
                                                       input logic [POS_WIDTH-1:0] hi);
      mirror_pos = hi - (x - lo);
   endfunction

   state_type                state_ff, state_in;

   logic [POS_WIDTH-1:0]     cfg_start_ff, cfg_start_in;
   logic [POS_WIDTH-1:0]     cfg_end_ff, cfg_end_in;
   logic [POS_WIDTH-1:0]     cfg_first_ff, cfg_first_in;
   logic [POS_WIDTH-1:0]     cfg_second_ff, cfg_second_in;
   logic signed [LOOP_W-1:0] cfg_loops_ff, cfg_loops_in;
   logic [POS_WIDTH-1:0]     cfg_init_ff, cfg_init_in;
   logic [SPEED_W-1:0]       cfg_speed_ff, cfg_speed_in;

   logic [POS_WIDTH-1:0]     cur_ff, cur_in;
   logic signed [LOOP_W-1:0] loops_ff, loops_in;
   logic                     reverse_ff, reverse_in;
   logic [POS_WIDTH-1:0]     nstart_ff, nstart_in;
   logic [POS_WIDTH-1:0]     nend_ff, nend_in;
   logic [POS_WIDTH-1:0]     nls_ff, nls_in;
   logic [POS_WIDTH-1:0]     nle_ff, nle_in;

   logic [POS_WIDTH-1:0]     ra_ff, ra_in;
   logic [POS_WIDTH-1:0]     rb_ff, rb_in;
   logic [POS_WIDTH-1:0]     rt_ff, rt_in;
   logic [POS_WIDTH-1:0]     old_ff, old_in;

   logic                     out_valid_ff, out_valid_in;
   logic [FIELD_W-1:0]       out_pos_ff, out_pos_in;
   logic signed [LOOP_W-1:0] out_loops_ff, out_loops_in;
   logic                     out_changed_ff, out_changed_in;
   logic                     out_stopped_ff, out_stopped_in;

   logic [XW-1:0]        value_x, wdata_x, rep_x;
   logic [POS_WIDTH-1:0] value_p, wdata_p, rep;
   logic                 accept;

   lpp_cmd_type          cmd;
   logic [POS_WIDTH-1:0] arith_opd, arith_src;
   logic                 arith_busy;
   logic [AW-1:0]        arith_result;

   logic [STEP_W-1:0]    step_raw;
   logic [CM-1:0]        step_c;
   logic [POS_WIDTH-1:0] step_sat;
   logic [POS_WIDTH:0]   step_sum;
   logic                 loops_zero, loops_pos, wrap_go;

   assign value_x = XW'(req_ch.value);
   assign value_p = value_x[POS_WIDTH-1:0];
   assign wdata_x = XW'(csr_wdata);
   assign wdata_p = wdata_x[POS_WIDTH-1:0];
   assign accept  = req_ch.valid && req_ch.ready;

   assign loops_zero = (loops_ff == '0);
   assign loops_pos  = !loops_ff[LOOP_W-1] && !loops_zero;
   assign wrap_go    = !loops_zero && (rt_ff > nle_ff) && (nle_ff != nls_ff);

   assign step_raw = arith_result[PROD_W-1:SPEED_FRAC];
   assign step_c   = CM'(step_raw);
   assign step_sat = (step_c > CM'(POS_MAX)) ? POS_MAX : step_c[POS_WIDTH-1:0];
   assign step_sum = {1'b0, cur_ff} + {1'b0, step_sat};

   assign rep   = reverse_ff ? mirror_pos(cur_ff, nstart_ff, nend_ff) : cur_ff;
   assign rep_x = XW'(rep);

   always_comb begin
      cmd.start = 1'b0;
      cmd.op    = OP_MUL;
      arith_opd = value_p;
      arith_src = POS_WIDTH'(cfg_speed_ff) << (POS_WIDTH - SPEED_W);
      if (state_ff == S_CHECK) begin
         cmd.start = wrap_go;
         cmd.op    = OP_REM;
         arith_opd = nle_ff - nls_ff;
         arith_src = rt_ff - nle_ff;
      end else if (accept && req_ch.action == ACT_ADVANCE) begin
         cmd.start = 1'b1;
      end
   end

   lpp_arith #(
      .POS_WIDTH (POS_WIDTH)
   ) u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opd    (arith_opd),
      .src    (arith_src),
      .busy   (arith_busy),
      .result (arith_result)
   );

   always_comb begin
      cfg_start_in  = cfg_start_ff;
      cfg_end_in    = cfg_end_ff;
      cfg_first_in  = cfg_first_ff;
      cfg_second_in = cfg_second_ff;
      cfg_loops_in  = cfg_loops_ff;
      cfg_init_in   = cfg_init_ff;
      cfg_speed_in  = cfg_speed_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RANGE_START: cfg_start_in  = wdata_p;
            CSR_RANGE_END:   cfg_end_in    = wdata_p;
            CSR_LOOP_FIRST:  cfg_first_in  = wdata_p;
            CSR_LOOP_SECOND: cfg_second_in = wdata_p;
            CSR_LOOP_COUNT:  cfg_loops_in  = csr_wdata[LOOP_W-1:0];
            CSR_INIT_POS:    cfg_init_in   = wdata_p;
            CSR_SPEED:       cfg_speed_in  = csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      loops_in       = loops_ff;
      reverse_in     = reverse_ff;
      nstart_in      = nstart_ff;
      nend_in        = nend_ff;
      nls_in         = nls_ff;
      nle_in         = nle_ff;
      ra_in          = ra_ff;
      rb_in          = rb_ff;
      rt_in          = rt_ff;
      old_in         = old_ff;
      out_valid_in   = out_valid_ff && !rsp_ch.ready;
      out_pos_in     = out_pos_ff;
      out_loops_in   = out_loops_ff;
      out_changed_in = out_changed_ff;
      out_stopped_in = out_stopped_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               old_in = cur_ff;
               rt_in  = value_p;
               unique case (req_ch.action)
                  ACT_ADVANCE: state_in = S_MUL;
                  ACT_SEEK:    state_in = S_SEEK;
                  ACT_RESTART: state_in = S_SORT;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_MUL: begin
            if (!arith_busy) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            rt_in    = step_sum[POS_WIDTH] ? POS_MAX : step_sum[POS_WIDTH-1:0];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (loops_zero) begin
               cur_in   = (rt_ff > nend_ff) ? nend_ff : rt_ff;
               state_in = S_DONE;
            end else if (rt_ff > nle_ff) begin
               if (nle_ff == nls_ff) begin
                  // empty loop: jump to the end and stop looping
                  cur_in   = nend_ff;
                  loops_in = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_REM;
               end
            end else begin
               cur_in   = rt_ff;
               state_in = S_DONE;
            end
         end
         S_REM: begin
            if (!arith_busy) begin
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            cur_in = nls_ff + arith_result[POS_WIDTH-1:0];
            if (loops_pos) begin
               loops_in = loops_ff - LOOP_W'(1);
            end
            state_in = S_DONE;
         end
         S_SEEK: begin
            cur_in   = clamp_pos(rt_ff, nstart_ff, nend_ff);
            state_in = S_FIX;
         end
         S_FIX: begin
            if (reverse_ff) begin
               cur_in = mirror_pos(cur_ff, nstart_ff, nend_ff);
            end
            state_in = S_DONE;
         end
         S_SORT: begin
            if (cfg_start_ff > cfg_end_ff) begin
               nstart_in = cfg_end_ff;
               nend_in   = cfg_start_ff;
            end else begin
               nstart_in = cfg_start_ff;
               nend_in   = cfg_end_ff;
            end
            reverse_in = cfg_first_ff > cfg_second_ff;
            if (cfg_first_ff > cfg_second_ff) begin
               ra_in = cfg_second_ff;
               rb_in = cfg_first_ff;
            end else begin
               ra_in = cfg_first_ff;
               rb_in = cfg_second_ff;
            end
            rt_in    = cfg_init_ff;
            loops_in = cfg_loops_ff;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            ra_in    = clamp_pos(ra_ff, nstart_ff, nend_ff);
            rb_in    = clamp_pos(rb_ff, nstart_ff, nend_ff);
            rt_in    = clamp_pos(rt_ff, nstart_ff, nend_ff);
            state_in = S_MIRROR;
         end
         S_MIRROR: begin
            if (reverse_ff) begin
               nls_in = mirror_pos(rb_ff, nstart_ff, nend_ff);
               nle_in = mirror_pos(ra_ff, nstart_ff, nend_ff);
               cur_in = mirror_pos(rt_ff, nstart_ff, nend_ff);
            end else begin
               nls_in = ra_ff;
               nle_in = rb_ff;
               cur_in = rt_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in   = 1'b1;
               out_pos_in     = rep_x[FIELD_W-1:0];
               out_loops_in   = loops_ff;
               out_changed_in = (cur_ff != old_ff);
               out_stopped_in = (cur_ff >= nend_ff) && loops_zero;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         out_valid_ff  <= 1'b0;
         cfg_start_ff  <= '0;
         cfg_end_ff    <= '0;
         cfg_first_ff  <= '0;
         cfg_second_ff <= '0;
         cfg_loops_ff  <= '0;
         cfg_init_ff   <= '0;
         cfg_speed_ff  <= SPEED_ONE;
         cur_ff        <= '0;
         loops_ff      <= '0;
         reverse_ff    <= 1'b0;
         nstart_ff     <= '0;
         nend_ff       <= '0;
         nls_ff        <= '0;
         nle_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         cfg_start_ff  <= cfg_start_in;
         cfg_end_ff    <= cfg_end_in;
         cfg_first_ff  <= cfg_first_in;
         cfg_second_ff <= cfg_second_in;
         cfg_loops_ff  <= cfg_loops_in;
         cfg_init_ff   <= cfg_init_in;
         cfg_speed_ff  <= cfg_speed_in;
         cur_ff        <= cur_in;
         loops_ff      <= loops_in;
         reverse_ff    <= reverse_in;
         nstart_ff     <= nstart_in;
         nend_ff       <= nend_in;
         nls_ff        <= nls_in;
         nle_ff        <= nle_in;
      end
      ra_ff          <= ra_in;
      rb_ff          <= rb_in;
      rt_ff          <= rt_in;
      old_ff         <= old_in;
      out_pos_ff     <= out_pos_in;
      out_loops_ff   <= out_loops_in;
      out_changed_ff <= out_changed_in;
      out_stopped_ff <= out_stopped_in;
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.position   = out_pos_ff;
   assign rsp_ch.loops_left = out_loops_ff;
   assign rsp_ch.changed    = out_changed_ff;
   assign rsp_ch.stopped    = out_stopped_ff;

endmodule

>>> sv/lpp_arith.sv
module lpp_arith #(
   parameter int POS_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpp_pkg::lpp_cmd_type   cmd,
   input  logic [POS_WIDTH-1:0]   opd,
   input  logic [POS_WIDTH-1:0]   src,
   output logic                   busy,
   output logic [((POS_WIDTH + 1 > lpp_pkg::PROD_W) ? POS_WIDTH + 1 : lpp_pkg::PROD_W)-1:0]
                                  result
);
   import lpp_pkg::*;

   localparam int AW = (POS_WIDTH + 1 > PROD_W) ? POS_WIDTH + 1 : PROD_W;
   localparam int CW = $clog2(POS_WIDTH + 1);

   // shared shift/add-subtract unit: MSB-first multiply or restoring remainder
   logic                 busy_ff, busy_in;
   lpp_op_type           op_ff, op_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        acc_ff, acc_in;
   logic [POS_WIDTH-1:0] opd_ff, opd_in;
   logic [POS_WIDTH-1:0] src_ff, src_in;

   logic [AW-1:0] acc_sh;
   logic [AW-1:0] addend;
   logic          cin;
   logic [AW:0]   sum;

   always_comb begin
      acc_sh = {acc_ff[AW-2:0], (op_ff == OP_REM) ? src_ff[POS_WIDTH-1] : 1'b0};
      if (op_ff == OP_REM) begin
         addend = ~AW'(opd_ff);
         cin    = 1'b1;
      end else begin
         addend = src_ff[POS_WIDTH-1] ? AW'(opd_ff) : '0;
         cin    = 1'b0;
      end
      sum = {1'b0, acc_sh} + {1'b0, addend} + (AW+1)'(cin);
   end

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opd_in  = opd_ff;
      src_in  = src_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = (cmd.op == OP_MUL) ? CW'(SPEED_W) : CW'(POS_WIDTH);
         acc_in  = '0;
         opd_in  = opd;
         src_in  = src;
      end else if (busy_ff) begin
         if (op_ff == OP_REM) begin
            acc_in = sum[AW] ? sum[AW-1:0] : acc_sh;
         end else begin
            acc_in = sum[AW-1:0];
         end
         src_in  = {src_ff[POS_WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opd_ff <= opd_in;
      src_ff <= src_in;
   end

   assign busy   = busy_ff;
   assign result = acc_ff;

endmodule

>>> test/playback_position_checker.sv
module playback_position_checker (
   input  logic                          clock,
   input  logic                          reset,
   lpp_req_if                            req_ch,
   lpp_rsp_if                            rsp_ch,
   input  logic                          csr_we,
   input  logic [lpp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lpp_pkg::FIELD_W-1:0]   csr_wdata,
   output int                            fail_count,
   output int                            pending_items
);
   import lpp_pkg::*;

   typedef struct packed {
      logic [FIELD_W-1:0]       position;
      logic signed [LOOP_W-1:0] loops_left;
      logic                     changed;
      logic                     stopped;
   } position_report_type;

   localparam logic [63:0] POS_MAX = 64'hFFFF_FFFF;

   // register copies, loaded into the working state on restart
   logic [FIELD_W-1:0]       range_a_q, range_b_q, loop_a_q, loop_b_q, init_pos_q;
   logic signed [LOOP_W-1:0] loop_count_q;
   logic [SPEED_W-1:0]       speed_q;

   logic [FIELD_W-1:0]       cur_pos, span_lo, span_hi, loop_lo, loop_hi;
   logic signed [LOOP_W-1:0] loops_rem;
   logic                     reversed;

   position_report_type expected_reports[$];
   int errors = 0;

   assign fail_count = errors;

   function automatic logic [FIELD_W-1:0] clamp_pos(input logic [FIELD_W-1:0] x,
                                                    input logic [FIELD_W-1:0] lo,
                                                    input logic [FIELD_W-1:0] hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   function automatic logic [FIELD_W-1:0] mirror_pos(input logic [FIELD_W-1:0] x);
      return span_hi - (x - span_lo);
   endfunction

   function automatic position_report_type play_step(input logic [1:0] act,
                                                     input logic [FIELD_W-1:0] val);
      logic [FIELD_W-1:0]  old_pos, lo, hi, p, q, t0;
      logic [63:0]         whole, frac, step, t, len;
      position_report_type rep;
      old_pos = cur_pos;
      case (act)
         ACT_ADVANCE: begin
            whole = {40'd0, val[31:8]};
            frac  = ({56'd0, val[7:0]} * {48'd0, speed_q}) >> 8;
            if (speed_q != 0 && whole > (POS_MAX - frac) / {48'd0, speed_q}) begin
               step = POS_MAX;
            end else begin
               step = whole * {48'd0, speed_q} + frac;
            end
            if (step > POS_MAX - {32'd0, cur_pos}) begin
               t = POS_MAX;
            end else begin
               t = {32'd0, cur_pos} + step;
            end
            if (loops_rem == 0) begin
               if (t > {32'd0, span_hi}) t = {32'd0, span_hi};
            end else if (t > {32'd0, loop_hi}) begin
               len = {32'd0, loop_hi - loop_lo};
               // empty loop: jump to the end and stop looping
               if (len == 0) begin
                  t = {32'd0, span_hi};
                  loops_rem = '0;
               end else begin
                  t = {32'd0, loop_lo} + (t - {32'd0, loop_hi}) % len;
               end
               if (loops_rem > 0) loops_rem = loops_rem - LOOP_W'(1);
            end
            cur_pos = t[31:0];
         end
         ACT_SEEK: begin
            p = clamp_pos(val, span_lo, span_hi);
            cur_pos = reversed ? mirror_pos(p) : p;
         end
         ACT_RESTART: begin
            lo = (range_a_q > range_b_q) ? range_b_q : range_a_q;
            hi = (range_a_q > range_b_q) ? range_a_q : range_b_q;
            p  = (loop_a_q > loop_b_q) ? loop_b_q : loop_a_q;
            q  = (loop_a_q > loop_b_q) ? loop_a_q : loop_b_q;
            span_lo = lo;
            span_hi = hi;
            p  = clamp_pos(p, lo, hi);
            q  = clamp_pos(q, lo, hi);
            t0 = clamp_pos(init_pos_q, lo, hi);
            loops_rem = loop_count_q;
            reversed  = loop_a_q > loop_b_q;
            if (reversed) begin
               loop_lo = mirror_pos(q);
               loop_hi = mirror_pos(p);
               cur_pos = mirror_pos(t0);
            end else begin
               loop_lo = p;
               loop_hi = q;
               cur_pos = t0;
            end
         end
         default: ;
      endcase
      rep.position   = reversed ? mirror_pos(cur_pos) : cur_pos;
      rep.loops_left = loops_rem;
      rep.changed    = cur_pos != old_pos;
      rep.stopped    = (cur_pos >= span_hi) && (loops_rem == 0);
      return rep;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected %h, got %h", name, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      position_report_type want;
      if (reset) begin
         range_a_q    = '0;
         range_b_q    = '0;
         loop_a_q     = '0;
         loop_b_q     = '0;
         init_pos_q   = '0;
         loop_count_q = '0;
         speed_q      = SPEED_ONE;
         cur_pos      = '0;
         loops_rem    = '0;
         reversed     = 1'b0;
         span_lo      = '0;
         span_hi      = '0;
         loop_lo      = '0;
         loop_hi      = '0;
         expected_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RANGE_START: range_a_q    = csr_wdata;
               CSR_RANGE_END:   range_b_q    = csr_wdata;
               CSR_LOOP_FIRST:  loop_a_q     = csr_wdata;
               CSR_LOOP_SECOND: loop_b_q     = csr_wdata;
               CSR_LOOP_COUNT:  loop_count_q = csr_wdata[LOOP_W-1:0];
               CSR_INIT_POS:    init_pos_q   = csr_wdata;
               CSR_SPEED:       speed_q      = csr_wdata[SPEED_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_reports.size() == 0) begin
               $error("result item with no expectation pending");
               errors++;
            end else begin
               want = expected_reports.pop_front();
               check_field("position", want.position, rsp_ch.position);
               check_field("loops_left", {15'd0, want.loops_left}, {15'd0, rsp_ch.loops_left});
               check_field("changed", {31'd0, want.changed}, {31'd0, rsp_ch.changed});
               check_field("stopped", {31'd0, want.stopped}, {31'd0, rsp_ch.stopped});
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_reports.push_back(play_step(req_ch.action, req_ch.value));
         end
      end
      pending_items <= expected_reports.size();
   end

endmodule

>>> test/loop_playback_position_unit_tb.sv
module loop_playback_position_unit_tb;
   import lpp_pkg::*;

   localparam logic [1:0] ACT_UNUSED     = 2'd3;
   localparam int         TOTAL_ITEMS    = 1150;
   localparam int         BLOCK_ITEMS    = 40;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         WATCHDOG_LIMIT = 5000;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_RANGE_START;
   logic [FIELD_W-1:0]   csr_wdata   = '0;
   logic                 rsp_ready_q = 1'b0;

   int fail_count, pending_items;
   int send_idle_pct = 33;
   int rsp_idle_pct  = 86;
   bit hold_go   = 1'b0;
   bit hold_done = 1'b0;
   int hold_left    = 0;
   int stuck_cycles = 0;
   int items_sent   = 0;

   logic [31:0] delta_span = 32'hFFFF;
   logic [31:0] near_base  = '0;
   logic [31:0] near_win   = '0;

   lpp_req_if req_ch ();
   lpp_rsp_if rsp_ch ();

   assign rsp_ch.ready = rsp_ready_q;

   loop_playback_position_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   playback_position_checker position_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_items (pending_items)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off to back up the unit
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left   <= hold_left - 1;
         rsp_ready_q <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_left   <= HOLD_CYCLES;
         hold_done   <= 1'b1;
         rsp_ready_q <= 1'b0;
      end else begin
         rsp_ready_q <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic push_item(input logic [1:0] act, input logic [31:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.value  <= val;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_items != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] s, e, f, sc, init,
                               input logic [16:0] cnt, input logic [15:0] spd);
      logic [31:0] noise;
      logic [63:0] len;
      noise = $urandom;
      write_reg(CSR_RANGE_START, s);
      write_reg(CSR_RANGE_END, e);
      write_reg(CSR_LOOP_FIRST, f);
      write_reg(CSR_LOOP_SECOND, sc);
      write_reg(CSR_LOOP_COUNT, {noise[31:17], cnt});
      write_reg(CSR_INIT_POS, init);
      write_reg(CSR_SPEED, {noise[15:0], spd});
      csr_we <= 1'b0;
      // deltas up to about two loop lengths at this speed
      len = {32'd0, (f > sc) ? f - sc : sc - f};
      len = ((len << 9) / ((spd == 0) ? 64'd1 : {48'd0, spd})) + 64'd256;
      delta_span = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
      near_base  = (s < e) ? s : e;
      near_win   = (s < e) ? e - s : s - e;
   endtask

   task automatic program_random();
      logic [31:0] base, win, lo, s, e, f, sc, init;
      logic [16:0] cnt;
      logic [15:0] spd;
      base = $urandom;
      win  = 32'd1 << $urandom_range(24, 8);
      case ($urandom_range(7))
         0: begin
            s = $urandom;
            e = $urandom;
         end
         1: begin
            s = 32'hFFFF_FFFF;
            e = '0;
         end
         default: begin
            s = base;
            e = base + win;
         end
      endcase
      lo = (s < e) ? s : e;
      f  = lo + $urandom_range(win, 0);
      sc = lo + $urandom_range(win, 0);
      if ($urandom_range(7) == 0) f = $urandom;
      if ($urandom_range(15) == 0) sc = f;
      init = ($urandom_range(3) == 0) ? $urandom : lo + $urandom_range(win, 0);
      case ($urandom_range(7))
         0: cnt = 17'h1FFFF;
         1: cnt = 17'h10000;
         2: cnt = '0;
         3: cnt = 17'h0FFFF;
         4: cnt = 17'($urandom);
         default: cnt = 17'($urandom_range(6, 1));
      endcase
      case ($urandom_range(7))
         0: spd = '0;
         1: spd = 16'hFFFF;
         2: spd = SPEED_ONE;
         3: spd = 16'($urandom);
         default: spd = 16'($urandom_range(1024, 64));
      endcase
      program_regs(s, e, f, sc, init, cnt, spd);
   endtask

   initial begin
      int r;
      req_ch.valid  = 1'b0;
      req_ch.action = ACT_ADVANCE;
      req_ch.value  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty range straight out of reset
      push_item(ACT_ADVANCE, 32'h0001_0000);
      push_item(ACT_SEEK, 32'hFFFF_FFFF);
      push_item(ACT_UNUSED, '0);
      settle();

      // range ends given reversed, init below range, two wraps then saturate
      program_regs(32'h0010_0000, 32'h0001_0000, 32'h0002_0000, 32'h0008_0000, '0,
                   17'd2, SPEED_ONE);
      push_item(ACT_RESTART, '0);
      push_item(ACT_ADVANCE, 32'h0005_0000);
      push_item(ACT_ADVANCE, 32'h0004_0000);
      push_item(ACT_ADVANCE, 32'h000D_0000);
      push_item(ACT_ADVANCE, 32'hFFFF_FFFF);
      push_item(ACT_SEEK, '0);
      push_item(ACT_SEEK, 32'hFFFF_FFFF);
      settle();

      // reverse playback, loop forever, full speed, full range
      program_regs('0, 32'hFFFF_FFFF, 32'h0008_0000, 32'h0002_0000, 32'h0003_0000,
                   17'h1FFFF, 16'hFFFF);
      push_item(ACT_RESTART, 32'hFFFF_FFFF);
      push_item(ACT_ADVANCE, 32'h0000_0100);
      push_item(ACT_ADVANCE, 32'h0001_0000);
      push_item(ACT_SEEK, 32'h0005_0000);
      push_item(ACT_ADVANCE, 32'hFFFF_FFFF);
      settle();

      // empty loop forces the end
      program_regs('0, 32'h0010_0000, 32'h0004_0000, 32'h0004_0000, '0, 17'd3, 16'h0080);
      push_item(ACT_RESTART, '0);
      push_item(ACT_ADVANCE, 32'h0000_1234);
      push_item(ACT_ADVANCE, 32'h0020_0000);
      push_item(ACT_UNUSED, 32'hFFFF_FFFF);

      while (items_sent < TOTAL_ITEMS) begin
         settle();
         if (items_sent >= 2 * TOTAL_ITEMS / 3) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end else if (items_sent >= TOTAL_ITEMS / 3) begin
            send_idle_pct = 86;
            rsp_idle_pct  = 33;
         end
         program_random();
         if (send_idle_pct == 0) hold_go = 1'b1;
         push_item(ACT_RESTART, $urandom);
         repeat (BLOCK_ITEMS - 1) begin
            r = $urandom_range(99);
            if (r < 55)      push_item(ACT_ADVANCE, $urandom_range(delta_span, 0));
            else if (r < 63) push_item(ACT_ADVANCE, $urandom);
            else if (r < 68) push_item(ACT_ADVANCE, $urandom_range(255, 0));
            else if (r < 78) push_item(ACT_SEEK, $urandom);
            else if (r < 86) push_item(ACT_SEEK, near_base + $urandom_range(near_win, 0));
            else if (r < 92) push_item(ACT_RESTART, $urandom);
            else if (r < 96) push_item(ACT_UNUSED, $urandom);
            else             push_item(ACT_ADVANCE, '0);
         end
      end

      settle();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_items == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/lpp_pkg.sv
sv/lpp_if.sv
sv/lpp_arith.sv
sv/loop_playback_position_unit.sv
test/playback_position_checker.sv
test/loop_playback_position_unit_tb.sv
